// ===== design/four_level_page_table_walker_assert.svh =====
// assertion macros for the page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// clocked check, skipped while reset is asserted
`define FLTW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, also evaluated during reset
`define FLTW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fltw_pkg.sv =====
`timescale 1ns / 1ps

package fltw_pkg;

	localparam int AddrWidth  = 64;
	localparam int VaHeld     = 48;
	localparam int IndexWidth = 9;
	localparam int PaddrWidth = 4;

	localparam logic CMD_TRANSLATE = 1'b0;
	localparam logic CMD_ENTRY     = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] LEVEL_PML4 = 2'd3;
	localparam logic [1:0] LEVEL_PDPT = 2'd2;
	localparam logic [1:0] LEVEL_PD   = 2'd1;
	localparam logic [1:0] LEVEL_PT   = 2'd0;

	localparam logic REG_TABLE_ROOT    = 1'b0;
	localparam logic REG_IDENTITY_MODE = 1'b1;

	localparam int LargeBit = 7;

	typedef struct packed {
		logic                 kind;
		logic [AddrWidth-1:0] address;
		logic [1:0]           walk_level;
	} fltw_result_t;

	function automatic logic [IndexWidth-1:0] table_index(
		input logic [VaHeld-1:0] va,
		input logic [1:0]        level
	);
		logic [IndexWidth-1:0] idx;
		unique case (level)
			LEVEL_PML4: idx = va[47:39];
			LEVEL_PDPT: idx = va[38:30];
			LEVEL_PD:   idx = va[29:21];
			default:    idx = va[20:12];
		endcase
		return idx;
	endfunction

	function automatic logic [AddrWidth-1:0] entry_address(
		input logic [AddrWidth-1:0]  base,
		input logic [IndexWidth-1:0] idx
	);
		return {12'b0, base[51:12], idx, 3'b000};
	endfunction

endpackage

// ===== design/four_level_page_table_walker.sv =====
`timescale 1ns / 1ps

// Four-level page table walker. Each transaction on the request channel is a
// translate request or a page table entry returned from memory; each yields
// at most one transaction on the response channel: a read request for the
// next entry (kind 0) or the finished physical address (kind 1). The block
// takes one transaction per cycle sustained while rsp_ready does not stall it;
// a request passes the input register, then the result register, before its
// response becomes valid, and the result register lets a new request in while
// a response waits.
// A translate request during a walk and an entry while idle give no response.
// Configuration: table_root at byte address 0, identity_mode at byte address
// 8, both 64-bit APB registers; write them only while the block is idle.
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker import fltw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PaddrWidth-1:0] paddr,
	input  logic [AddrWidth-1:0]  pwdata,
	output logic [AddrWidth-1:0]  prdata,
	output logic                  pready,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  cmd,
	input  logic [AddrWidth-1:0]  vaddr,
	input  logic [AddrWidth-1:0]  table_entry,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  kind,
	output logic [AddrWidth-1:0]  address,
	output logic [1:0]            walk_level
);

	logic [AddrWidth-1:0] table_root_q;
	logic                 identity_mode_q;

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [AddrWidth-1:0] va_s1;
	logic [AddrWidth-1:0] entry_s1;

	logic              busy_q;
	logic [1:0]        level_q;
	logic [VaHeld-1:0] held_va_q;

	logic              busy_d;
	logic [1:0]        level_d;
	logic [VaHeld-1:0] held_va_d;

	logic         res_valid;
	fltw_result_t res;

	logic         out_valid_q;
	fltw_result_t out_q;

	logic out_free;
	logic advance;
	logic req_fire;
	logic cfg_write;
	logic reg_sel;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = paddr[PaddrWidth-1];

	always_comb begin
		unique case (reg_sel)
			REG_TABLE_ROOT:    prdata = table_root_q;
			default:           prdata = {{(AddrWidth-1){1'b0}}, identity_mode_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_root_q    <= '0;
			identity_mode_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_TABLE_ROOT:    table_root_q    <= pwdata;
				default:           identity_mode_q <= pwdata[0];
			endcase
		end
	end

	assign out_free  = !out_valid_q || rsp_ready;
	assign advance   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || advance;
	assign req_fire  = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1   <= cmd;
			va_s1    <= vaddr;
			entry_s1 <= table_entry;
		end
	end

	always_comb begin
		busy_d    = busy_q;
		level_d   = level_q;
		held_va_d = held_va_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_READ, address: '0, walk_level: LEVEL_PT};
		if (cmd_s1 == CMD_TRANSLATE) begin
			if (!busy_q) begin
				res_valid = 1'b1;
				if (identity_mode_q) begin
					res = '{kind: KIND_DONE, address: va_s1, walk_level: LEVEL_PT};
				end else begin
					held_va_d = va_s1[VaHeld-1:0];
					level_d   = LEVEL_PML4;
					busy_d    = 1'b1;
					res = '{kind: KIND_READ,
						address: entry_address(table_root_q,
							table_index(va_s1[VaHeld-1:0], LEVEL_PML4)),
						walk_level: LEVEL_PML4};
				end
			end
		end else if (busy_q) begin
			res_valid = 1'b1;
			priority if (level_q == LEVEL_PT) begin
				busy_d = 1'b0;
				res = '{kind: KIND_DONE,
					address: {12'b0, entry_s1[51:12], held_va_q[11:0]},
					walk_level: LEVEL_PT};
			end else if (level_q == LEVEL_PDPT && entry_s1[LargeBit]) begin
				busy_d  = 1'b0;
				level_d = LEVEL_PT;
				res = '{kind: KIND_DONE,
					address: {12'b0, entry_s1[51:30], held_va_q[29:0]},
					walk_level: LEVEL_PDPT};
			end else if (level_q == LEVEL_PD && entry_s1[LargeBit]) begin
				busy_d  = 1'b0;
				level_d = LEVEL_PT;
				res = '{kind: KIND_DONE,
					address: {12'b0, entry_s1[51:21], held_va_q[20:0]},
					walk_level: LEVEL_PD};
			end else begin
				level_d = level_q - 2'd1;
				res = '{kind: KIND_READ,
					address: entry_address(entry_s1, table_index(held_va_q, level_d)),
					walk_level: level_d};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			level_q   <= LEVEL_PT;
			held_va_q <= '0;
		end else if (advance) begin
			busy_q    <= busy_d;
			level_q   <= level_d;
			held_va_q <= held_va_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign kind       = out_q.kind;
	assign address    = out_q.address;
	assign walk_level = out_q.walk_level;

	`FLTW_ASSERT(a_done_level,
		out_valid_q && out_q.kind == KIND_DONE |-> out_q.walk_level != LEVEL_PML4,
		"finished translation reported at top level")
	`FLTW_ASSERT(a_read_keeps_busy,
		advance && res_valid && res.kind == KIND_READ |=> busy_q,
		"read request issued without an active walk")
	`FLTW_ASSERT(a_top_descends,
		advance && cmd_s1 == CMD_ENTRY && busy_q && level_q == LEVEL_PML4 |=>
			out_valid_q && out_q.kind == KIND_READ && out_q.walk_level == LEVEL_PDPT,
		"top level entry did not descend")
	`FLTW_ASSERT(a_identity_passthru,
		advance && cmd_s1 == CMD_TRANSLATE && !busy_q && identity_mode_q |=>
			out_q.address == $past(va_s1) && out_q.kind == KIND_DONE,
		"identity translation changed the address")

endmodule
